@@ rtl/sma_pkg.sv @@
// ----------------------------------------------------------------------------
// sma_pkg
// Types, register codes and sizes shared by the selection mask alpha block.
// ----------------------------------------------------------------------------
`default_nettype none

package sma_pkg;

  localparam int unsigned MAX_SIDE_DEFAULT = 4096;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_COLS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_COLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_ROWS = 3'd5;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
    logic [7:0]  alpha_in;
    logic [7:0]  mask_value;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [7:0] alpha_out;
  } pix_out_t;

endpackage

`default_nettype wire

@@ rtl/sma_if.sv @@
// ----------------------------------------------------------------------------
// sma_in_if / sma_out_if
// Valid/ready channels for pixels entering and leaving the block.
// ----------------------------------------------------------------------------
`default_nettype none

interface sma_in_if;
  logic             valid;
  logic             ready;
  sma_pkg::pix_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sma_out_if;
  logic              valid;
  logic              ready;
  sma_pkg::pix_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/selection_mask_alpha_apply.sv @@
// ----------------------------------------------------------------------------
// selection_mask_alpha_apply
// Scales premultiplied BGRA pixels by a selection mask inside a rectangle.
// ----------------------------------------------------------------------------
// Usage: pixels arrive on pix_in with their surface coordinates and mask
// byte; one result per pixel leaves on pix_out in arrival order. The mask
// and surface geometry is written through cfg_we/cfg_index/cfg_data while
// no pixel is in flight; sizes above MAX_SIDE are saturated on write.
// Throughput is one pixel per cycle while pix_out.ready is held high: the
// un-premultiply division is a restoring divider spread over four stages
// at two quotient bits each, followed by a multiply stage and a
// divide-by-255 stage. Each stage has its own valid bit and moves when the
// stage after it is free, so bubbles are squeezed out. When the receiver
// stalls, the filled stages hold and pix_in.ready drops once all are full.
// Synchronous reset empties the pipeline and restores the register defaults
// (mask at origin with zero size, surface MAX_SIDE by MAX_SIDE).
// ----------------------------------------------------------------------------
`default_nettype none

module selection_mask_alpha_apply #(
  parameter int unsigned MAX_SIDE = sma_pkg::MAX_SIDE_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [sma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [sma_pkg::CFG_W-1:0]          cfg_data,
  sma_in_if.sink                            pix_in,
  sma_out_if.source                         pix_out
);
  import sma_pkg::*;

  localparam int NST = 7;

  typedef struct packed {
    logic             pass;
    logic             zero;
    logic [7:0]       b;
    logic [7:0]       g;
    logic [7:0]       r;
    logic [7:0]       a;
    logic [7:0]       na;
    logic [2:0]       sat;
    logic [2:0][7:0]  rem;
    logic [2:0][7:0]  nlow;
    logic [2:0][7:0]  q;
    logic [2:0][15:0] prod;
    logic [2:0][7:0]  res;
  } stage_t;

  logic signed [CFG_W-1:0] mask_left;
  logic signed [CFG_W-1:0] mask_top;
  logic [CFG_W-1:0] mask_cols;
  logic [CFG_W-1:0] mask_rows;
  logic [CFG_W-1:0] surface_cols;
  logic [CFG_W-1:0] surface_rows;

  function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    if (32'(v) > MAX_SIDE) return CFG_W'(MAX_SIDE);
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_left    <= '0;
      mask_top     <= '0;
      mask_cols    <= '0;
      mask_rows    <= '0;
      surface_cols <= clamp_side(CFG_W'(MAX_SIDE));
      surface_rows <= clamp_side(CFG_W'(MAX_SIDE));
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASK_LEFT:    mask_left    <= cfg_data;
        CFG_MASK_TOP:     mask_top     <= cfg_data;
        CFG_MASK_COLS:    mask_cols    <= clamp_side(cfg_data);
        CFG_MASK_ROWS:    mask_rows    <= clamp_side(cfg_data);
        CFG_SURFACE_COLS: surface_cols <= clamp_side(cfg_data);
        CFG_SURFACE_ROWS: surface_rows <= clamp_side(cfg_data);
        default: ;
      endcase
    end
  end

  function automatic logic in_span(input logic [11:0] p, input logic [CFG_W-1:0] org,
                                   input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] lim);
    logic signed [CFG_W+1:0] ps;
    logic signed [CFG_W+1:0] os;
    logic signed [CFG_W+1:0] es;
    ps = $signed({3'b000, p});
    os = $signed({{2{org[CFG_W-1]}}, org});
    es = os + $signed({2'b00, len});
    return (ps >= os) && (ps < es) && ({1'b0, p} < lim);
  endfunction

  // floor(x/255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // two restoring quotient bits for each color
  function automatic stage_t div2(input stage_t s);
    stage_t o;
    logic [8:0] t;
    o = s;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 2; i++) begin
        t = {o.rem[c], o.nlow[c][7]};
        o.nlow[c] = {o.nlow[c][6:0], 1'b0};
        if (t >= {1'b0, o.a}) begin
          t = t - {1'b0, o.a};
          o.q[c] = {o.q[c][6:0], 1'b1};
        end else begin
          o.q[c] = {o.q[c][6:0], 1'b0};
        end
        o.rem[c] = t[7:0];
      end
    end
    return o;
  endfunction

  stage_t stg [NST];
  stage_t nxt [NST];
  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  always_comb begin
    stage_t   s;
    logic [15:0] p;
    logic [7:0] cv [3];
    logic [15:0] n;
    logic [7:0] u;
    logic in_reg;
    // entry stage
    s = '0;
    in_reg = in_span(pix_in.data.pos_x, mask_left, mask_cols, surface_cols) &&
             in_span(pix_in.data.pos_y, mask_top, mask_rows, surface_rows);
    s.pass = !(in_reg && pix_in.data.alpha_in != 8'd0 && pix_in.data.mask_value != 8'd255);
    s.b = pix_in.data.blue_in;
    s.g = pix_in.data.green_in;
    s.r = pix_in.data.red_in;
    s.a = pix_in.data.alpha_in;
    p = 16'(pix_in.data.alpha_in) * 16'(pix_in.data.mask_value);
    s.na = div255(p);
    s.zero = (s.na == 8'd0);
    cv[0] = s.b;
    cv[1] = s.g;
    cv[2] = s.r;
    for (int c = 0; c < 3; c++) begin
      n = {cv[c], 8'd0} - {8'd0, cv[c]} + {9'd0, s.a[7:1]};
      s.sat[c] = (cv[c] >= s.a);
      s.rem[c] = n[15:8];
      s.nlow[c] = n[7:0];
    end
    nxt[0] = s;
    for (int k = 1; k < 5; k++) nxt[k] = div2(stg[k-1]);
    // re-premultiply with the new alpha
    s = stg[4];
    for (int c = 0; c < 3; c++) begin
      u = s.sat[c] ? 8'd255 : s.q[c];
      s.prod[c] = 16'(u) * 16'(s.na) + 16'd127;
    end
    nxt[5] = s;
    s = stg[5];
    for (int c = 0; c < 3; c++) s.res[c] = div255(s.prod[c]);
    nxt[6] = s;
  end

  assign adv[NST-1] = !vld[NST-1] || pix_out.ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= (k == 0) ? pix_in.valid : vld[(k == 0) ? 0 : k - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        stg[k] <= nxt[k];
      end
    end
  end

  assign pix_in.ready = adv[0];
  assign pix_out.valid = vld[NST-1];

  always_comb begin
    stage_t o;
    o = stg[NST-1];
    if (o.pass) begin
      pix_out.data = '{blue_out: o.b, green_out: o.g, red_out: o.r, alpha_out: o.a};
    end else if (o.zero) begin
      pix_out.data = '0;
    end else begin
      pix_out.data = '{blue_out: o.res[0], green_out: o.res[1], red_out: o.res[2],
                       alpha_out: o.na};
    end
  end

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("pipeline not empty after reset");

  // a held stage never drops its transaction
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    vld[NST-1] && !adv[NST-1] |=> vld[NST-1])
    else $error("stalled result lost");

  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !adv[3] |=> vld[3])
    else $error("stalled divider stage lost");

  // mask can only lower alpha
  a_alpha_drop: assert property (@(posedge clk) disable iff (rst)
    vld[NST-1] && !stg[NST-1].pass |-> stg[NST-1].na <= stg[NST-1].a)
    else $error("new alpha above old alpha");

endmodule

`default_nettype wire

@@ test/selection_mask_alpha_apply_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// selection_mask_alpha_apply_tb
// Drives pixels through the mask alpha block under several region settings,
// predicts every result and checks it field by field, with random stalls on
// both channels and one long hold-off at the output.
// ----------------------------------------------------------------------------

class alpha_mask_scoreboard;
  int signed   left_pos, top_pos;
  int unsigned cols, rows, surf_cols, surf_rows;
  sma_pkg::pix_out_t pending_pixels[$];
  int errors;

  function new();
    errors = 0;
    set_defaults();
  endfunction

  function void set_defaults();
    left_pos = 0; top_pos = 0; cols = 0; rows = 0;
    surf_cols = 4096; surf_rows = 4096;
  endfunction

  function void write_reg(logic [2:0] idx, logic [12:0] val);
    int unsigned side;
    side = (val > 4096) ? 4096 : val;
    case (idx)
      sma_pkg::CFG_MASK_LEFT:    left_pos = $signed(val);
      sma_pkg::CFG_MASK_TOP:     top_pos = $signed(val);
      sma_pkg::CFG_MASK_COLS:    cols = side;
      sma_pkg::CFG_MASK_ROWS:    rows = side;
      sma_pkg::CFG_SURFACE_COLS: surf_cols = side;
      sma_pkg::CFG_SURFACE_ROWS: surf_rows = side;
      default: ;
    endcase
  endfunction

  function bit in_span(int signed p, int signed org, int unsigned len, int unsigned lim);
    return p >= org && p < org + int'(len) && p < int'(lim);
  endfunction

  function logic [7:0] rescale(int unsigned c, int unsigned a, int unsigned na);
    int unsigned u;
    u = (c * 255 + a / 2) / a;
    if (u > 255) u = 255;
    return 8'((u * na + 127) / 255);
  endfunction

  function void note_pixel(sma_pkg::pix_in_t p);
    sma_pkg::pix_out_t o;
    int unsigned na;
    o = '{p.blue_in, p.green_in, p.red_in, p.alpha_in};
    if (in_span(p.pos_x, left_pos, cols, surf_cols) &&
        in_span(p.pos_y, top_pos, rows, surf_rows) &&
        p.alpha_in != 0 && p.mask_value != 255) begin
      na = (p.alpha_in * p.mask_value) / 255;
      if (na == 0) begin
        o = '0;
      end else begin
        o.blue_out = rescale(p.blue_in, p.alpha_in, na);
        o.green_out = rescale(p.green_in, p.alpha_in, na);
        o.red_out = rescale(p.red_in, p.alpha_in, na);
        o.alpha_out = 8'(na);
      end
    end
    pending_pixels.push_back(o);
  endfunction

  function void check_pixel(sma_pkg::pix_out_t got);
    sma_pkg::pix_out_t exp_px;
    if (pending_pixels.size() == 0) begin
      $error("unexpected pixel %h", got);
      errors++;
      return;
    end
    exp_px = pending_pixels.pop_front();
    if (got.blue_out !== exp_px.blue_out) begin
      $error("blue_out expected %0d got %0d", exp_px.blue_out, got.blue_out); errors++;
    end
    if (got.green_out !== exp_px.green_out) begin
      $error("green_out expected %0d got %0d", exp_px.green_out, got.green_out); errors++;
    end
    if (got.red_out !== exp_px.red_out) begin
      $error("red_out expected %0d got %0d", exp_px.red_out, got.red_out); errors++;
    end
    if (got.alpha_out !== exp_px.alpha_out) begin
      $error("alpha_out expected %0d got %0d", exp_px.alpha_out, got.alpha_out); errors++;
    end
  endfunction
endclass

module selection_mask_alpha_apply_tb;
  import sma_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int cycle_count = 0;
  int hold_count = 0;
  bit random_idle = 1'b0;
  bit drain_done = 1'b0;

  sma_in_if pix_in ();
  sma_out_if pix_out ();

  alpha_mask_scoreboard sb = new();

  selection_mask_alpha_apply i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix_in(pix_in.sink), .pix_out(pix_out.source)
  );

  always #4 clk = ~clk;

  initial begin
    pix_in.valid = 1'b0;
    pix_in.data = '0;
    pix_out.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("selection_mask_alpha_apply verification failed");
      $finish;
    end
  end

  // output side: checks and random back-pressure
  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) sb.check_pixel(pix_out.data);
  end

  always @(negedge clk) begin
    if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= random_idle ? ($urandom_range(99) >= 25) : 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_region(logic [12:0] l, logic [12:0] t, logic [12:0] c,
                            logic [12:0] r, logic [12:0] sc, logic [12:0] sr);
    write_reg(CFG_MASK_LEFT, l);
    write_reg(CFG_MASK_TOP, t);
    write_reg(CFG_MASK_COLS, c);
    write_reg(CFG_MASK_ROWS, r);
    write_reg(CFG_SURFACE_COLS, sc);
    write_reg(CFG_SURFACE_ROWS, sr);
  endtask

  // valid stays high between back-to-back transactions
  task automatic send_pixel(pix_in_t p);
    if (random_idle) begin
      while ($urandom_range(99) < 25) begin
        pix_in.valid <= 1'b0;
        @(negedge clk);
      end
    end
    pix_in.valid <= 1'b1;
    pix_in.data <= p;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic wait_empty();
    pix_in.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic pix_in_t random_pixel();
    pix_in_t p;
    p = {$urandom, $urandom};
    case ($urandom_range(7))
      0: p.mask_value = 8'd0;
      1: p.mask_value = 8'd255;
      2: p.alpha_in = 8'd0;
      3: p.alpha_in = 8'd255;
      default: ;
    endcase
    // keep many pixels near the mask window so the region edges get hit
    if ($urandom_range(3) != 0) begin
      p.pos_x = 12'($urandom_range(40));
      p.pos_y = 12'($urandom_range(40));
    end
    return p;
  endfunction

  initial begin
    pix_in_t p;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default geometry: empty mask, everything passes
    send_pixel('{12'd0, 12'd0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd128});
    wait_empty();

    set_region(13'd0, 13'd0, 13'd4096, 13'd4096, 13'd4096, 13'd4096);
    send_pixel('{12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd128});
    send_pixel('{12'd4095, 12'd4095, 8'd0, 8'd0, 8'd0, 8'd255, 8'd1});
    send_pixel('{12'd5, 12'd5, 8'd9, 8'd8, 8'd7, 8'd0, 8'd100});
    send_pixel('{12'd5, 12'd5, 8'd9, 8'd8, 8'd7, 8'd20, 8'd255});
    send_pixel('{12'd5, 12'd5, 8'd9, 8'd8, 8'd7, 8'd20, 8'd0});
    send_pixel('{12'd5, 12'd5, 8'd9, 8'd8, 8'd7, 8'd1, 8'd254});
    send_pixel('{12'd5, 12'd5, 8'd200, 8'd1, 8'd99, 8'd3, 8'd200});
    send_pixel('{12'd2730, 12'd1365, 8'd170, 8'd85, 8'd255, 8'd170, 8'd85});
    wait_empty();

    // oversized values saturate; negative origin
    set_region(13'h1000, 13'h1FFF, 13'h1FFF, 13'd3, 13'd10, 13'h1FFF);
    send_pixel('{12'd9, 12'd1, 8'd50, 8'd60, 8'd70, 8'd100, 8'd100});
    send_pixel('{12'd10, 12'd1, 8'd50, 8'd60, 8'd70, 8'd100, 8'd100});
    send_pixel('{12'd0, 12'd2, 8'd50, 8'd60, 8'd70, 8'd100, 8'd100});
    wait_empty();

    set_region(13'd4095, 13'd7, 13'd1, 13'd0, 13'd1, 13'd1);
    send_pixel('{12'd0, 12'd0, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5});
    wait_empty();

    // random phases over several windows
    for (int phase = 0; phase < 5; phase++) begin
      set_region(13'($urandom_range(20) - 10), 13'($urandom_range(20) - 10),
                 13'($urandom_range(40)), 13'($urandom_range(40)),
                 13'($urandom_range(40, 1)), 13'($urandom_range(40, 1)));
      random_idle = (phase != 1);
      if (phase == 2) hold_count = 200;
      for (int n = 0; n < 200; n++) send_pixel(random_pixel());
      wait_empty();
    end

    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0) begin
      $display("selection_mask_alpha_apply verification clean");
    end else begin
      $display("selection_mask_alpha_apply verification failed");
    end
    $finish;
  end
endmodule
